/* src/tphb_pkg.sv */
// Shared types, constants and header helpers for the TCP probe header builder.
package tphb_pkg;

    localparam int unsigned HDR_WORDS   = 10;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned Q_DEPTH     = 2;
    localparam int unsigned ACC_W       = 20;

    localparam logic [7:0]  TTL_RESET    = 8'd64;
    localparam logic [15:0] WINDOW_RESET = 16'd4096;
    localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
    localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
    localparam logic [15:0] IP_TOTAL_LEN = 16'd40;
    localparam logic [15:0] IP_VER_TOS   = 16'h4500;
    localparam logic [3:0]  TCP_DATA_OFF = 4'd5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TTL    = 1'b0,
        REG_WINDOW = 1'b1
    } t_cfg_reg;

    typedef enum logic [IDX_W-1:0] {
        W_VER_LEN   = 4'd0,
        W_IDENT     = 4'd1,
        W_TTL_CSUM  = 4'd2,
        W_SRC       = 4'd3,
        W_DST       = 4'd4,
        W_PORTS     = 4'd5,
        W_SEQ       = 4'd6,
        W_ACK       = 4'd7,
        W_OFF_WIN   = 4'd8,
        W_TCP_CSUM  = 4'd9
    } t_word_sel;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] sequence_number;
        logic [7:0]  tcp_flags;
        logic [15:0] ip_ident;
    } t_probe_in;

    typedef struct packed {
        logic [31:0]      header_word;
        logic [IDX_W-1:0] word_index;
        logic             last_word;
    } t_hdr_out;

    // one classified probe, ready to be serialised
    typedef struct packed {
        t_probe_in   probe;
        logic [7:0]  ttl;
        logic [15:0] window;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } t_probe_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // end-around carry fold and complement
    function automatic logic [15:0] fold_cpl(input logic [ACC_W-1:0] acc);
        logic [16:0] a;
        logic [16:0] b;
        a = 17'(acc[ACC_W-1:16]) + 17'(acc[15:0]);
        b = 17'(a[15:0]) + 17'(a[16]);
        return ~b[15:0];
    endfunction

    function automatic logic [31:0] hdr_word(input t_probe_rec rec,
                                             input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = '0;
        case (t_word_sel'(idx))
            W_VER_LEN:  w = {IP_VER_TOS, IP_TOTAL_LEN};
            W_IDENT:    w = {rec.probe.ip_ident, 16'h0000};
            W_TTL_CSUM: w = {rec.ttl, IP_PROTO_TCP, rec.ip_csum};
            W_SRC:      w = rec.probe.src_address;
            W_DST:      w = rec.probe.dst_address;
            W_PORTS:    w = {rec.probe.src_port, rec.probe.dst_port};
            W_SEQ:      w = rec.probe.sequence_number;
            W_ACK:      w = '0;
            W_OFF_WIN:  w = {TCP_DATA_OFF, 4'h0, rec.probe.tcp_flags, rec.window};
            W_TCP_CSUM: w = {rec.tcp_csum, 16'h0000};
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

/* src/tphb_front.sv */
// Front end: config registers, word intake and two-stage checksum pipeline.
module tphb_front import tphb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_probe_in             i_in_word,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_probe_rec            o_push_rec
);

    logic [7:0]  r_ttl;
    logic [15:0] r_window;

    logic        r_v1, r_v2;
    t_probe_in   r_p1, r_p2;
    logic [7:0]  r_ttl1, r_ttl2;
    logic [15:0] r_win1, r_win2;
    logic [17:0] r_sum_addr, r_sum_ip, r_sum_tcp, r_sum_hdr;
    logic [ACC_W-1:0] r_ip_acc, r_tcp_acc;

    logic adv1, adv2, take;
    logic [17:0] n_sum_addr, n_sum_ip, n_sum_tcp, n_sum_hdr;

    assign o_push     = r_v2 && !i_q_stat.full;
    assign adv2       = !r_v2 || o_push;
    assign adv1       = !r_v1 || adv2;
    assign o_in_stall = !adv1;
    assign take       = i_in_valid && adv1;

    always_comb begin
        n_sum_addr = 18'(i_in_word.src_address[31:16]) + 18'(i_in_word.src_address[15:0])
                   + 18'(i_in_word.dst_address[31:16]) + 18'(i_in_word.dst_address[15:0]);
        n_sum_ip   = 18'(i_in_word.ip_ident) + 18'({r_ttl, IP_PROTO_TCP})
                   + 18'(IP_VER_TOS) + 18'(IP_TOTAL_LEN);
        n_sum_tcp  = 18'(i_in_word.src_port) + 18'(i_in_word.dst_port)
                   + 18'(i_in_word.sequence_number[31:16])
                   + 18'(i_in_word.sequence_number[15:0]);
        // pseudo-header protocol and length, plus offset/flags and window
        n_sum_hdr  = 18'({TCP_DATA_OFF, 4'h0, i_in_word.tcp_flags}) + 18'(r_window)
                   + 18'(IP_PROTO_TCP) + 18'(TCP_HDR_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl    <= TTL_RESET;
            r_window <= WINDOW_RESET;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_TTL:    r_ttl    <= i_cfg_data[7:0];
                    REG_WINDOW: r_window <= i_cfg_data;
                endcase
            end
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (take) begin
            r_p1       <= i_in_word;
            r_ttl1     <= r_ttl;
            r_win1     <= r_window;
            r_sum_addr <= n_sum_addr;
            r_sum_ip   <= n_sum_ip;
            r_sum_tcp  <= n_sum_tcp;
            r_sum_hdr  <= n_sum_hdr;
        end
        if (adv2 && r_v1) begin
            r_p2      <= r_p1;
            r_ttl2    <= r_ttl1;
            r_win2    <= r_win1;
            r_ip_acc  <= ACC_W'(r_sum_addr) + ACC_W'(r_sum_ip);
            r_tcp_acc <= ACC_W'(r_sum_addr) + ACC_W'(r_sum_tcp) + ACC_W'(r_sum_hdr);
        end
    end

    always_comb begin
        o_push_rec.probe    = r_p2;
        o_push_rec.ttl      = r_ttl2;
        o_push_rec.window   = r_win2;
        o_push_rec.ip_csum  = fold_cpl(r_ip_acc);
        o_push_rec.tcp_csum = fold_cpl(r_tcp_acc);
    end

endmodule

/* src/tphb_queue.sv */
// Small register queue of classified probes between front and back.
module tphb_queue import tphb_pkg::*; #(
    parameter int unsigned DEPTH = Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_probe_rec i_push_rec,
    input  logic       i_pop,
    output t_probe_rec o_head,
    output t_q_stat    o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_probe_rec    r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wr] <= i_push_rec;
    end

endmodule

/* src/tphb_back.sv */
// Back end: serialises each queued probe into ten header words.
module tphb_back import tphb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_probe_rec i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_hdr_out   o_out_word
);

    logic             r_valid;
    t_hdr_out         r_word;
    logic [IDX_W-1:0] r_idx;
    logic             load;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !i_q_stat.empty && (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
            if (!i_q_stat.empty)
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
        if (load && !i_q_stat.empty) begin
            r_word.header_word <= hdr_word(i_head, r_idx);
            r_word.word_index  <= r_idx;
            r_word.last_word   <= (r_idx == LAST_IDX);
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

/* src/tcp_probe_header_builder.sv */
// A probe word passes through the front checksum pipeline and the queue; the
// serialiser then registers one header word per cycle while i_out_stall is low.
// Up to QUEUE_DEPTH + 2 probes are held, counting the one being serialised.
// Reset (synchronous, active low) empties pipeline, queue and output register,
// and sets TTL to 64 and window to 4096.
module tcp_probe_header_builder import tphb_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_probe_in             i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_hdr_out              o_out_word
);

    t_q_stat    q_stat;
    t_probe_rec push_rec, head;
    logic       push, pop;

    tphb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_rec  (push_rec)
    );

    tphb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    tphb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* src/tphb_checker.sv */
// Port-level checks for the TCP probe header builder, bound to the top level.
module tphb_checker import tphb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_probe_in             i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_hdr_out              o_out_word
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.last_word == (o_out_word.word_index == LAST_IDX)))
        else $error("last_word out of step with word_index");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.word_index == '0) |->
            (o_out_word.header_word == {IP_VER_TOS, IP_TOTAL_LEN}))
        else $error("bad version/length word");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_out_word.word_index != LAST_IDX)) ##1 o_out_valid
            |-> (o_out_word.word_index == $past(o_out_word.word_index) + 1'b1))
        else $error("word_index skipped");

endmodule

bind tcp_probe_header_builder tphb_checker u_tphb_checker (.*);
